// ----- rtl/rti_pkg.sv -----
// shared types and constants of the ray/triangle intersection pipeline
package rti_pkg;

   localparam int CW      = 32;           // coordinate width, signed Q16.16
   localparam int FB      = 16;           // fraction bits
   localparam int DET_MIN = 1;            // smallest |det| that is not parallel
   localparam int EW      = CW + 1;       // edge and offset vectors
   localparam int XW      = 2 * EW + 1;   // cross product components
   localparam int PW      = XW + EW;      // one term of a dot product
   localparam int DW      = PW + 2;       // dot product sums
   localparam int LW      = 22;           // low limbs of a split multiply
   localparam int PPW     = EW + LW + 1;  // partial product width
   localparam int QW      = 31;           // distance width
   localparam int RW      = DW + QW;      // divider remainder width
   localparam int LATENCY = 8 + QW + 1;   // accept to result strobe

   localparam logic [QW-1:0] DIST_MAX = {QW{1'b1}};

   localparam int NUM_CSR = 6;
   localparam int CSR_AW  = 3;
   localparam int CSR_ORIGIN_X = 0;
   localparam int CSR_DIR_X    = 3;

   typedef struct packed {
      logic signed [CW-1:0] v0_x;
      logic signed [CW-1:0] v0_y;
      logic signed [CW-1:0] v0_z;
      logic signed [CW-1:0] v1_x;
      logic signed [CW-1:0] v1_y;
      logic signed [CW-1:0] v1_z;
      logic signed [CW-1:0] v2_x;
      logic signed [CW-1:0] v2_y;
      logic signed [CW-1:0] v2_z;
   } req_type;

   typedef struct packed {
      logic          hit;
      logic [QW-1:0] distance;
   } rsp_type;

   typedef struct packed {
      logic          vld;
      logic          hit;
      logic [DW-1:0] num;
      logic [DW-1:0] den;
   } div_req_type;

endpackage

// ----- rtl/rti_mul.sv -----
// two-stage signed multiplier, wide operand split into three limbs
module rti_mul import rti_pkg::*; (
   input  logic                 clock,
   input  logic signed [XW-1:0] a,
   input  logic signed [EW-1:0] b,
   output logic signed [PW-1:0] p
);

   logic signed [PPW-1:0] pp0_ff, pp1_ff, pp2_ff;
   logic signed [PPW-1:0] pp0_in, pp1_in, pp2_in;
   logic signed [PW-1:0]  p_ff, p_in;
   logic signed [PW-1:0]  ext0_w, ext1_w, ext2_w;

   always_comb begin
      pp0_in = b * $signed({1'b0, a[LW-1:0]});
      pp1_in = b * $signed({1'b0, a[2*LW-1:LW]});
      pp2_in = b * $signed(a[XW-1:2*LW]);
   end

   always_ff @(posedge clock) begin
      pp0_ff <= pp0_in;
      pp1_ff <= pp1_in;
      pp2_ff <= pp2_in;
   end

   always_comb begin
      ext0_w = $signed({{(PW-PPW){pp0_ff[PPW-1]}}, pp0_ff});
      ext1_w = $signed({{(PW-PPW){pp1_ff[PPW-1]}}, pp1_ff});
      ext2_w = $signed({{(PW-PPW){pp2_ff[PPW-1]}}, pp2_ff});
      p_in   = (ext2_w <<< (2 * LW)) + (ext1_w <<< LW) + ext0_w;
   end

   always_ff @(posedge clock) begin
      p_ff <= p_in;
   end

   assign p = p_ff;

endmodule

// ----- rtl/rti_div.sv -----
// pipelined restoring divider for the distance, one quotient bit per stage
module rti_div import rti_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output logic        rsp_valid,
   output rsp_type     rsp_payload
);

   logic [RW-1:0] rem_ff [QW];
   logic [DW-1:0] den_ff [QW];
   logic [QW-1:0] quo_ff [QW+1];
   logic          sat_ff [QW+1];
   logic          hit_ff [QW+1];
   logic          vld_ff [QW+1];

   logic [RW-1:0] num0_in;
   logic          sat0_in;

   // saturate when num * 2^FB >= den * 2^QW
   always_comb begin
      num0_in = {{(RW-DW){1'b0}}, div_req.num} << FB;
      sat0_in = num0_in >= ({{(RW-DW){1'b0}}, div_req.den} << QW);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else begin
         vld_ff[0] <= div_req.vld;
      end
      hit_ff[0] <= div_req.hit;
      sat_ff[0] <= sat0_in;
      rem_ff[0] <= num0_in;
      den_ff[0] <= div_req.den;
      quo_ff[0] <= '0;
   end

   for (genvar j = 1; j <= QW; j++) begin : g_stage
      localparam int K = QW - j;
      logic [RW-1:0] sub_w;
      logic          take_w;
      logic [RW-1:0] rem_in;
      logic [QW-1:0] quo_in;

      always_comb begin
         sub_w     = {{(RW-DW){1'b0}}, den_ff[j-1]} << K;
         take_w    = rem_ff[j-1] >= sub_w;
         rem_in    = take_w ? (rem_ff[j-1] - sub_w) : rem_ff[j-1];
         quo_in    = quo_ff[j-1];
         quo_in[K] = take_w;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[j] <= 1'b0;
         end else begin
            vld_ff[j] <= vld_ff[j-1];
         end
         hit_ff[j] <= hit_ff[j-1];
         sat_ff[j] <= sat_ff[j-1];
         quo_ff[j] <= quo_in;
      end

      if (j < QW) begin : g_carry
         always_ff @(posedge clock) begin
            rem_ff[j] <= rem_in;
            den_ff[j] <= den_ff[j-1];
         end
      end
   end

   assign rsp_valid            = vld_ff[QW];
   assign rsp_payload.hit      = hit_ff[QW];
   assign rsp_payload.distance = !hit_ff[QW] ? '0 : (sat_ff[QW] ? DIST_MAX : quo_ff[QW]);

endmodule

// ----- rtl/ray_triangle_intersect.sv -----
// ray/triangle intersection pipeline, top level
// Takes one triangle per clock and never backs up: busy stays low, and the
// result of each triangle comes out on a one-cycle rsp_valid strobe, in
// order. The depth is set by eight arithmetic stages (edges, cross
// products, split multiplies, dot sums, sign fix, bounds tests), a divider
// input register and a restoring divider that yields one bit of the
// distance per stage. The ray registers are read straight by the pipeline,
// so change them only with no triangle in flight.
module ray_triangle_intersect import rti_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  req_type           req_payload,
   output logic              rsp_valid,
   output rsp_type           rsp_payload,
   input  logic              csr_we,
   input  logic [CSR_AW-1:0] csr_addr,
   input  logic [CW-1:0]     csr_wdata
);

   logic signed [CW-1:0] ray_ff [NUM_CSR];
   logic                 accept_w;
   logic [7:0]           vld_ff;

   logic signed [EW-1:0] v0_w [3];
   logic signed [EW-1:0] v1_w [3];
   logic signed [EW-1:0] v2_w [3];
   logic signed [EW-1:0] org_w [3];
   logic signed [EW-1:0] dir_w [3];

   logic signed [EW-1:0] e1_s1_ff [3];
   logic signed [EW-1:0] e2_s1_ff [3];
   logic signed [EW-1:0] s_s1_ff [3];
   logic signed [EW-1:0] e1_s2_ff [3];
   logic signed [EW-1:0] e2_s2_ff [3];
   logic signed [EW-1:0] s_s2_ff [3];
   logic signed [EW-1:0] e1_s3_ff [3];
   logic signed [EW-1:0] e2_s3_ff [3];
   logic signed [EW-1:0] s_s3_ff [3];

   logic signed [2*EW-1:0] xh_ff [3][2];
   logic signed [2*EW-1:0] xq_ff [3][2];
   logic signed [XW-1:0]   h_ff [3];
   logic signed [XW-1:0]   q_ff [3];

   logic signed [XW-1:0] mul_a [4][3];
   logic signed [EW-1:0] mul_b [4][3];
   logic signed [PW-1:0] mul_p [4][3];

   logic signed [DW-1:0] dot_ff [4];
   logic signed [DW-1:0] fix_ff [4];
   logic                 hit_s8_ff;
   logic [DW-1:0]        num_s8_ff;
   logic [DW-1:0]        den_s8_ff;
   logic                 hit_s8_in;
   logic [DW:0]          uv_sum_w;

   div_req_type div_req;

   assign busy     = 1'b0;
   assign accept_w = start && !busy;

   // ray registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_CSR; i++) begin
            ray_ff[i] <= '0;
         end
      end else if (csr_we && (int'(csr_addr) < NUM_CSR)) begin
         ray_ff[csr_addr] <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[6:0], accept_w};
      end
   end

   always_comb begin
      v0_w[0] = EW'(req_payload.v0_x);
      v0_w[1] = EW'(req_payload.v0_y);
      v0_w[2] = EW'(req_payload.v0_z);
      v1_w[0] = EW'(req_payload.v1_x);
      v1_w[1] = EW'(req_payload.v1_y);
      v1_w[2] = EW'(req_payload.v1_z);
      v2_w[0] = EW'(req_payload.v2_x);
      v2_w[1] = EW'(req_payload.v2_y);
      v2_w[2] = EW'(req_payload.v2_z);
      for (int i = 0; i < 3; i++) begin
         org_w[i] = EW'(ray_ff[CSR_ORIGIN_X + i]);
         dir_w[i] = EW'(ray_ff[CSR_DIR_X + i]);
      end
   end

   // edges and origin offset
   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         e1_s1_ff[i] <= v1_w[i] - v0_w[i];
         e2_s1_ff[i] <= v2_w[i] - v0_w[i];
         s_s1_ff[i]  <= org_w[i] - v0_w[i];
         e1_s2_ff[i] <= e1_s1_ff[i];
         e2_s2_ff[i] <= e2_s1_ff[i];
         s_s2_ff[i]  <= s_s1_ff[i];
         e1_s3_ff[i] <= e1_s2_ff[i];
         e2_s3_ff[i] <= e2_s2_ff[i];
         s_s3_ff[i]  <= s_s2_ff[i];
      end
   end

   // h = dir x e2, q = s x e1
   for (genvar i = 0; i < 3; i++) begin : g_cross
      localparam int A = (i + 1) % 3;
      localparam int B = (i + 2) % 3;
      always_ff @(posedge clock) begin
         xh_ff[i][0] <= dir_w[A] * e2_s1_ff[B];
         xh_ff[i][1] <= dir_w[B] * e2_s1_ff[A];
         xq_ff[i][0] <= s_s1_ff[A] * e1_s1_ff[B];
         xq_ff[i][1] <= s_s1_ff[B] * e1_s1_ff[A];
         h_ff[i]     <= XW'(xh_ff[i][0]) - XW'(xh_ff[i][1]);
         q_ff[i]     <= XW'(xq_ff[i][0]) - XW'(xq_ff[i][1]);
      end
   end

   // dot product terms: det = e1.h, un = s.h, vn = dir.q, tn = e2.q
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         mul_a[0][i] = h_ff[i];
         mul_b[0][i] = e1_s3_ff[i];
         mul_a[1][i] = h_ff[i];
         mul_b[1][i] = s_s3_ff[i];
         mul_a[2][i] = q_ff[i];
         mul_b[2][i] = dir_w[i];
         mul_a[3][i] = q_ff[i];
         mul_b[3][i] = e2_s3_ff[i];
      end
   end

   for (genvar d = 0; d < 4; d++) begin : g_dot
      for (genvar i = 0; i < 3; i++) begin : g_term
         rti_mul u_mul (
            .clock (clock),
            .a     (mul_a[d][i]),
            .b     (mul_b[d][i]),
            .p     (mul_p[d][i])
         );
      end
      always_ff @(posedge clock) begin
         dot_ff[d] <= DW'(mul_p[d][0]) + DW'(mul_p[d][1]) + DW'(mul_p[d][2]);
      end
   end

   // make det positive, flipping the numerators with it
   always_ff @(posedge clock) begin
      for (int d = 0; d < 4; d++) begin
         fix_ff[d] <= dot_ff[0][DW-1] ? -dot_ff[d] : dot_ff[d];
      end
   end

   always_comb begin
      uv_sum_w  = {1'b0, fix_ff[1]} + {1'b0, fix_ff[2]};
      hit_s8_in = ($unsigned(fix_ff[0]) >= DW'(DET_MIN))
                  && !fix_ff[1][DW-1] && (fix_ff[1] <= fix_ff[0])
                  && !fix_ff[2][DW-1] && (uv_sum_w <= {1'b0, fix_ff[0]})
                  && !fix_ff[3][DW-1] && (fix_ff[3] != '0);
   end

   always_ff @(posedge clock) begin
      hit_s8_ff <= hit_s8_in;
      num_s8_ff <= fix_ff[3];
      den_s8_ff <= fix_ff[0];
   end

   always_comb begin
      div_req.vld = vld_ff[7];
      div_req.hit = hit_s8_ff;
      div_req.num = num_s8_ff;
      div_req.den = den_s8_ff;
   end

   rti_div u_div (
      .clock       (clock),
      .reset       (reset),
      .div_req     (div_req),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload)
   );

   a_latency: assert property (@(posedge clock) disable iff (reset)
      accept_w |-> ##LATENCY rsp_valid)
      else $error("item result missing at fixed latency");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.hit |-> rsp_payload.distance == '0)
      else $error("miss with nonzero distance");

   a_hit_det: assert property (@(posedge clock) disable iff (reset)
      vld_ff[7] && hit_s8_ff |-> den_s8_ff != '0 && num_s8_ff != '0)
      else $error("hit with zero determinant or distance numerator");

endmodule
